@@ hw/rtl/ir_beacon_duty_classifier_assert.svh @@
// Assertion macros for the IR beacon duty classifier checker.
// Expects clk and rst_n in scope at the point of use.
`ifndef IR_BEACON_DUTY_CLASSIFIER_ASSERT_SVH
`define IR_BEACON_DUTY_CLASSIFIER_ASSERT_SVH

// Check cons in the same cycle as ante
`define IRBDC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("irbdc assertion failed");

// Check cons in the cycle after ante
`define IRBDC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("irbdc assertion failed");

`endif

@@ hw/rtl/irbdc_pkg.sv @@
// Shared types and constants of the IR beacon duty classifier.
// Used by every module of the block; depends on nothing.
package irbdc_pkg;

    localparam int unsigned WS_W    = 16;
    localparam int unsigned GS_W    = 16;
    localparam int unsigned WPM_W   = 8;
    localparam int unsigned RATIO_W = 17;
    localparam int unsigned LOW_W   = 24;
    localparam int unsigned POS_W   = 17;
    localparam int unsigned TOT_W   = 24;
    localparam int unsigned ALU_W   = 26;
    localparam int unsigned QBIT_W  = 5;

    localparam logic [LOW_W-1:0]   LOW_MAX   = 24'hFF_FFFF;
    localparam logic [RATIO_W-1:0] RATIO_ONE = 17'h1_0000;

    localparam logic [WS_W-1:0]    WS_RESET  = 16'd10000;
    localparam logic [GS_W-1:0]    GS_RESET  = 16'd2000;
    localparam logic [WPM_W-1:0]   WPM_RESET = 8'd8;
    localparam logic [RATIO_W-1:0] AL_RESET  = 17'd13107;
    localparam logic [RATIO_W-1:0] AH_RESET  = 17'd20972;
    localparam logic [RATIO_W-1:0] BL_RESET  = 17'd26214;
    localparam logic [RATIO_W-1:0] BH_RESET  = 17'd29491;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_WINDOW_SAMPLES      = 3'd0,
        REG_GAP_SAMPLES         = 3'd1,
        REG_WINDOWS_PER_MEASURE = 3'd2,
        REG_BAND_A_LOW          = 3'd3,
        REG_BAND_A_HIGH         = 3'd4,
        REG_BAND_B_LOW          = 3'd5,
        REG_BAND_B_HIGH         = 3'd6
    } reg_index_t;

    // Beacon class codes
    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_600  = 2'd1,
        CLASS_1500 = 2'd2
    } class_t;

    // End of a measurement, handed from the sampler to the divider
    typedef struct packed {
        logic             start;
        logic [LOW_W-1:0] low;
        logic [WPM_W-1:0] wins;
    } meas_t;

    // Ratio band bounds
    typedef struct packed {
        logic [RATIO_W-1:0] a_low;
        logic [RATIO_W-1:0] a_high;
        logic [RATIO_W-1:0] b_low;
        logic [RATIO_W-1:0] b_high;
    } bands_t;

    // One finished result
    typedef struct packed {
        logic [LOW_W-1:0]   low;
        logic [RATIO_W-1:0] ratio;
        class_t             cls;
    } res_t;

endpackage

@@ hw/rtl/irbdc_sampler.sv @@
// Per-sample counters: low count, position in window plus gap, window count.
// Depends on irbdc_pkg.
module irbdc_sampler
    import irbdc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic             pin,
    input  logic [WS_W-1:0]  window_samples,
    input  logic [GS_W-1:0]  gap_samples,
    input  logic [WPM_W-1:0] windows_per_measure,
    output meas_t            meas
);

    logic [LOW_W-1:0] low_reg;
    logic [POS_W-1:0] pos_reg;
    logic [WPM_W-1:0] wins_reg;

    logic             in_window;
    logic [LOW_W-1:0] low_inc;
    logic [POS_W-1:0] pos_inc;
    logic [POS_W-1:0] span;
    logic             win_end;
    logic [WPM_W-1:0] wins_inc;
    logic [WPM_W-1:0] wanted;
    logic             meas_end;

    // Count low samples inside the counted part of the window
    assign in_window = pos_reg < {1'b0, window_samples};
    assign low_inc   = (in_window && !pin && (low_reg != LOW_MAX))
                       ? low_reg + LOW_W'(1) : low_reg;

    // Detect window and measurement ends
    assign pos_inc  = pos_reg + POS_W'(1);
    assign span     = {1'b0, window_samples} + {1'b0, gap_samples};
    assign win_end  = pos_inc >= span;
    assign wins_inc = wins_reg + WPM_W'(1);
    assign wanted   = (windows_per_measure == '0) ? WPM_W'(1) : windows_per_measure;
    assign meas_end = win_end && (wins_inc >= wanted);

    assign meas.start = accept && meas_end;
    assign meas.low   = low_inc;
    assign meas.wins  = wins_inc;

    // Advance counters on each transfer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_reg  <= '0;
            pos_reg  <= '0;
            wins_reg <= '0;
        end
        else if (accept)
        begin
            if (!win_end)
            begin
                pos_reg <= pos_inc;
                low_reg <= low_inc;
            end
            else
            begin
                pos_reg <= '0;
                if (meas_end)
                begin
                    low_reg  <= '0;
                    wins_reg <= '0;
                end
                else
                begin
                    low_reg  <= low_inc;
                    wins_reg <= wins_inc;
                end
            end
        end
    end

endmodule

@@ hw/rtl/irbdc_divider.sv @@
// Iterative ratio unit: one shared subtract/compare step per cycle forms
// low * 65536 / counted samples, then band classification. Depends on irbdc_pkg.
module irbdc_divider
    import irbdc_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  meas_t           meas,
    input  logic [WS_W-1:0] window_samples,
    input  bands_t          bands,
    input  logic            take,
    output logic            busy,
    output logic            res_valid,
    output res_t            res
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_DIV,
        ST_CLASS,
        ST_DONE
    } state_t;

    state_t              state_reg;
    logic [LOW_W-1:0]    low_reg;
    logic [WPM_W-1:0]    wins_reg;
    logic [TOT_W-1:0]    total_reg;
    logic [LOW_W-1:0]    rem_reg;
    logic [RATIO_W-1:0]  q_reg;
    logic [QBIT_W-1:0]   bit_reg;
    logic                zero_reg;
    res_t                res_reg;

    logic [ALU_W-1:0]    alu_a;
    logic [ALU_W-1:0]    alu_b;
    logic [ALU_W:0]      alu_diff;
    logic                alu_ge;
    logic [RATIO_W-1:0]  ratio;
    logic                in_a;
    logic                in_b;
    class_t              cls;

    // Select operands of the shared subtract unit
    always_comb
    begin
        alu_a = {2'b00, low_reg};
        alu_b = {1'b0, total_reg, 1'b0};
        if (state_reg == ST_DIV)
        begin
            alu_b = {2'b00, total_reg};
            if (bit_reg == QBIT_W'(RATIO_W - 1))
                alu_a = {2'b00, rem_reg};
            else
                alu_a = {1'b0, rem_reg, 1'b0};
        end
    end

    assign alu_diff = {1'b0, alu_a} - {1'b0, alu_b};
    assign alu_ge   = !alu_diff[ALU_W];

    // Clamp the quotient and match it against the bands
    assign ratio = (q_reg > RATIO_ONE) ? RATIO_ONE : q_reg;
    assign in_a  = (ratio >= bands.a_low) && (ratio <= bands.a_high);
    assign in_b  = (ratio >= bands.b_low) && (ratio <= bands.b_high);

    always_comb
    begin
        priority if (zero_reg)
            cls = CLASS_NONE;
        else if (in_a)
            cls = CLASS_600;
        else if (in_b)
            cls = CLASS_1500;
        else
            cls = CLASS_NONE;
    end

    assign busy      = state_reg != ST_IDLE;
    assign res_valid = state_reg == ST_DONE;
    assign res       = res_reg;

    // Sequence one measurement through multiply, range check, divide, classify
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            low_reg   <= '0;
            wins_reg  <= '0;
            total_reg <= '0;
            rem_reg   <= '0;
            q_reg     <= '0;
            bit_reg   <= '0;
            zero_reg  <= 1'b0;
            res_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (meas.start)
                    begin
                        low_reg   <= meas.low;
                        wins_reg  <= meas.wins;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MUL:
                begin
                    total_reg <= TOT_W'(wins_reg) * TOT_W'(window_samples);
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    zero_reg <= 1'b0;
                    if (total_reg == '0)
                    begin
                        zero_reg  <= 1'b1;
                        q_reg     <= '0;
                        state_reg <= ST_CLASS;
                    end
                    else if (alu_ge)
                    begin
                        // Quotient of at least two: saturate
                        q_reg     <= RATIO_ONE;
                        state_reg <= ST_CLASS;
                    end
                    else
                    begin
                        rem_reg   <= low_reg;
                        q_reg     <= '0;
                        bit_reg   <= QBIT_W'(RATIO_W - 1);
                        state_reg <= ST_DIV;
                    end
                end
                ST_DIV:
                begin
                    rem_reg <= alu_ge ? alu_diff[LOW_W-1:0] : alu_a[LOW_W-1:0];
                    q_reg   <= {q_reg[RATIO_W-2:0], alu_ge};
                    if (bit_reg == '0)
                        state_reg <= ST_CLASS;
                    else
                        bit_reg <= bit_reg - QBIT_W'(1);
                end
                ST_CLASS:
                begin
                    res_reg.low   <= low_reg;
                    res_reg.ratio <= zero_reg ? '0 : ratio;
                    res_reg.cls   <= cls;
                    state_reg     <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (take)
                        state_reg <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/ir_beacon_duty_classifier.sv @@
// Top level of the IR beacon duty classifier: configuration registers,
// sampler, ratio unit and output register. Depends on irbdc_pkg.
//
// Usage: s_axis carries one pin sample per transfer (tdata bit 0). The
// block counts low samples over windows_per_measure windows of
// window_samples counted samples, each followed by gap_samples ignored
// samples. After the sample that closes the last gap, one result goes out
// on m_axis: beacon class, Q1.16 low fraction and the low sample count.
// Throughput is one sample per cycle while the ratio unit is idle. The sample
// that ends a measurement starts the ratio unit (multiply, range check, 17
// restoring divide steps, classify, hand-off) while s_axis_tready is low;
// zero-total and saturated cases skip the divide steps. The result is visible
// in the cycle after hand-off. The output register lets sampling resume while
// the result waits; a second result stalls the ratio unit (and so s_axis) until
// m_axis_tready takes the first. Reset clears all counters and loads the
// default configuration. Write registers through cfg_we/cfg_index/cfg_data
// only while no measurement is in flight; the block does not enforce this.
module ir_beacon_duty_classifier
    import irbdc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] pin_level
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [1:0] beacon_class, [18:2] ratio_q16,
                                        // [42:19] low_total, rest zero
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    logic [WS_W-1:0]  ws_reg;
    logic [GS_W-1:0]  gs_reg;
    logic [WPM_W-1:0] wpm_reg;
    bands_t           bands_reg;

    logic             accept;
    logic             busy;
    logic             res_valid;
    logic             take;
    meas_t            meas;
    res_t             res;
    logic             m_valid_reg;
    logic [47:0]      m_data_reg;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg           <= WS_RESET;
            gs_reg           <= GS_RESET;
            wpm_reg          <= WPM_RESET;
            bands_reg.a_low  <= AL_RESET;
            bands_reg.a_high <= AH_RESET;
            bands_reg.b_low  <= BL_RESET;
            bands_reg.b_high <= BH_RESET;
        end
        else if (cfg_we)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_WINDOW_SAMPLES:      ws_reg           <= cfg_data[WS_W-1:0];
                REG_GAP_SAMPLES:         gs_reg           <= cfg_data[GS_W-1:0];
                REG_WINDOWS_PER_MEASURE: wpm_reg          <= cfg_data[WPM_W-1:0];
                REG_BAND_A_LOW:          bands_reg.a_low  <= cfg_data;
                REG_BAND_A_HIGH:         bands_reg.a_high <= cfg_data;
                REG_BAND_B_LOW:          bands_reg.b_low  <= cfg_data;
                REG_BAND_B_HIGH:         bands_reg.b_high <= cfg_data;
                default:                 ;
            endcase
        end
    end

    assign s_axis_tready = !busy;
    assign accept        = s_axis_tvalid && s_axis_tready;

    irbdc_sampler u_sampler (
        .clk                 (clk),
        .rst_n               (rst_n),
        .accept              (accept),
        .pin                 (s_axis_tdata[0]),
        .window_samples      (ws_reg),
        .gap_samples         (gs_reg),
        .windows_per_measure (wpm_reg),
        .meas                (meas)
    );

    irbdc_divider u_divider (
        .clk            (clk),
        .rst_n          (rst_n),
        .meas           (meas),
        .window_samples (ws_reg),
        .bands          (bands_reg),
        .take           (take),
        .busy           (busy),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Hold the result until the receiver takes it
    assign take = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_valid && take)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && take)
            m_data_reg <= {5'b00000, res.low, res.ratio, res.cls};
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

endmodule

@@ hw/rtl/irbdc_checker.sv @@
// Port-level checker for the IR beacon duty classifier, bound to the top.
// Depends on irbdc_pkg and ir_beacon_duty_classifier_assert.svh.
`include "ir_beacon_duty_classifier_assert.svh"

module irbdc_checker
    import irbdc_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // A stalled result holds
    `IRBDC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // Class code is always a defined one
    `IRBDC_ASSERT_SAME(a_class_code, m_axis_tvalid, m_axis_tdata[1:0] == CLASS_NONE || m_axis_tdata[1:0] == CLASS_600 || m_axis_tdata[1:0] == CLASS_1500)

    // Ratio never exceeds one
    `IRBDC_ASSERT_SAME(a_ratio_max, m_axis_tvalid, m_axis_tdata[18:2] <= RATIO_ONE)

    // A new result only comes from the ratio unit, while sampling was held
    `IRBDC_ASSERT_SAME(a_new_result, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind ir_beacon_duty_classifier irbdc_checker u_irbdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ bench/tb_ir_beacon_duty_classifier.sv @@
// Testbench for the IR beacon duty classifier: directed and random pin streams,
// checked transfer by transfer against a cycle-free predictor of the block.
// Depends on irbdc_pkg and the ir_beacon_duty_classifier RTL.
`timescale 1ns / 100ps

module tb_ir_beacon_duty_classifier;
    import irbdc_pkg::*;

    localparam int DRAIN_CYCLES    = 40;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int ITEMS_PER_PHASE = 200;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;
    logic        cfg_we;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    // Predictor copy of the configuration
    logic [15:0]      cfg_window;
    logic [15:0]      cfg_gap;
    logic [7:0]       cfg_windows;
    logic [16:0]      band_a_lo;
    logic [16:0]      band_a_hi;
    logic [16:0]      band_b_lo;
    logic [16:0]      band_b_hi;

    // Predictor copy of the counters
    logic [LOW_W-1:0] cnt_low;
    logic [16:0]      sample_pos;
    logic [7:0]       win_done;

    res_t measurements_due[$];

    int src_idle_pct;
    int snk_idle_pct;
    int src_burst;
    int snk_burst;
    int fault_count;
    int stall_cycles;

    ir_beacon_duty_classifier u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Advance the counters by one pin sample; return 1 when a measurement closes
    function automatic bit classify_sample(input logic pin, output res_t r);
        logic [7:0]  wanted;
        logic [63:0] counted;
        logic [63:0] num;
        logic [63:0] quot;
        logic [16:0] ratio;

        r = '0;
        if (sample_pos < cfg_window && pin == 1'b0 && cnt_low != LOW_MAX)
            cnt_low = cnt_low + 1'b1;
        sample_pos = sample_pos + 1'b1;
        if (sample_pos < cfg_window + cfg_gap)
            return 1'b0;

        // close the window; a measurement closes after the wanted count
        sample_pos = '0;
        win_done = win_done + 1'b1;
        wanted = (cfg_windows == 8'd0) ? 8'd1 : cfg_windows;
        if (win_done < wanted)
            return 1'b0;

        counted = win_done;
        counted = counted * cfg_window;
        r.low = cnt_low;
        if (counted == 64'd0) begin
            r.ratio = '0;
            r.cls = CLASS_NONE;
        end else begin
            num = {cnt_low, 16'h0000};
            quot = num / counted;
            ratio = (quot > 64'd65536) ? RATIO_ONE : quot[16:0];
            r.ratio = ratio;
            // band A wins where both bands hold the ratio
            if (ratio >= band_a_lo && ratio <= band_a_hi)
                r.cls = CLASS_600;
            else if (ratio >= band_b_lo && ratio <= band_b_hi)
                r.cls = CLASS_1500;
            else
                r.cls = CLASS_NONE;
        end
        cnt_low = '0;
        win_done = '0;
        return 1'b1;
    endfunction

    // Write one register, then mirror it in the predictor
    task automatic write_reg(input reg_index_t idx, input logic [16:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_WINDOW_SAMPLES:      cfg_window = value[15:0];
            REG_GAP_SAMPLES:         cfg_gap = value[15:0];
            REG_WINDOWS_PER_MEASURE: cfg_windows = value[7:0];
            REG_BAND_A_LOW:          band_a_lo = value;
            REG_BAND_A_HIGH:         band_a_hi = value;
            REG_BAND_B_LOW:          band_b_lo = value;
            REG_BAND_B_HIGH:         band_b_hi = value;
            default: ;
        endcase
        @(posedge clk);
    endtask

    // Send one pin sample, idling first at random, and record what it closes
    task automatic send_sample(input logic pin);
        res_t r;

        if (src_burst != 0)
            src_burst--;
        else if ($urandom_range(63) == 0)
            src_burst = 24;
        else begin
            while ($urandom_range(99) < src_idle_pct) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'd0, pin};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (classify_sample(pin, r))
            measurements_due.push_back(r);
    endtask

    // Send a run of samples, each low with the given percentage
    task automatic send_random(input int count, input int low_pct);
        for (int i = 0; i < count; i++)
            send_sample($urandom_range(99) >= low_pct);
    endtask

    // Drop valid, wait for every result, then let the ratio unit go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (measurements_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // Ratios 0 to full scale against overlapping bands at the range ends
    task automatic test_band_edges();
        write_reg(REG_WINDOW_SAMPLES, 17'd4);
        write_reg(REG_GAP_SAMPLES, 17'd0);
        write_reg(REG_WINDOWS_PER_MEASURE, 17'd1);
        write_reg(REG_BAND_A_LOW, 17'd0);
        write_reg(REG_BAND_A_HIGH, 17'd32768);
        write_reg(REG_BAND_B_LOW, 17'd32768);
        write_reg(REG_BAND_B_HIGH, 17'd65536);
        for (int lows = 0; lows <= 4; lows++)
            for (int i = 0; i < 4; i++)
                send_sample(i >= lows);
        settle();
    endtask

    // Band A with low above high never matches
    task automatic test_inverted_band();
        write_reg(REG_BAND_A_LOW, 17'd65536);
        write_reg(REG_BAND_A_HIGH, 17'd0);
        write_reg(REG_BAND_B_LOW, 17'd16384);
        write_reg(REG_BAND_B_HIGH, 17'd16384);
        for (int i = 0; i < 4; i++)
            send_sample(i != 0);
        for (int i = 0; i < 4; i++)
            send_sample(1'b1);
        for (int i = 0; i < 4; i++)
            send_sample(1'b0);
        settle();
    endtask

    // No counted samples and a window count of zero
    task automatic test_zero_window();
        write_reg(REG_WINDOW_SAMPLES, 17'd0);
        write_reg(REG_WINDOWS_PER_MEASURE, 17'd0);
        send_sample(1'b0);
        send_sample(1'b1);
        send_sample(1'b0);
        settle();
    endtask

    // Largest window count with one-sample windows
    task automatic test_max_windows();
        write_reg(REG_WINDOW_SAMPLES, 17'd1);
        write_reg(REG_WINDOWS_PER_MEASURE, 17'd255);
        send_random(255, 30);
        settle();
    endtask

    // Shrink the window mid measurement so the ratio saturates
    task automatic test_midrun_change();
        write_reg(REG_WINDOW_SAMPLES, 17'd8);
        write_reg(REG_WINDOWS_PER_MEASURE, 17'd2);
        for (int i = 0; i < 15; i++)
            send_sample(1'b0);
        settle();
        write_reg(REG_WINDOW_SAMPLES, 17'd1);
        send_sample(1'b0);
        settle();
    endtask

    // Longest window and gap, then longest gap alone, each cut short
    task automatic test_register_extremes();
        write_reg(REG_WINDOW_SAMPLES, 17'd65535);
        write_reg(REG_GAP_SAMPLES, 17'd65535);
        write_reg(REG_WINDOWS_PER_MEASURE, 17'd1);
        send_random(40, 50);
        settle();
        write_reg(REG_WINDOW_SAMPLES, 17'd4);
        write_reg(REG_GAP_SAMPLES, 17'd0);
        send_sample(1'b0);
        settle();
        write_reg(REG_WINDOW_SAMPLES, 17'd1);
        write_reg(REG_GAP_SAMPLES, 17'd65535);
        send_random(40, 50);
        settle();
        write_reg(REG_GAP_SAMPLES, 17'd0);
        send_sample(1'b1);
        settle();
    endtask

    // Random small setups, each followed by a random pin stream
    task automatic test_random_phase(input int src_pct, input int snk_pct);
        int sent;
        int count;
        logic [16:0] lo;
        logic [16:0] hi;
        logic [16:0] tmp;

        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        sent = 0;
        while (sent < ITEMS_PER_PHASE)
        begin
            write_reg(REG_WINDOW_SAMPLES,
                      17'(($urandom_range(15) == 0) ? 0 : $urandom_range(1, 12)));
            write_reg(REG_GAP_SAMPLES, 17'($urandom_range(0, 6)));
            write_reg(REG_WINDOWS_PER_MEASURE, 17'($urandom_range(0, 4)));
            // mostly ordered bands, sometimes inverted
            lo = 17'($urandom_range(0, 65536));
            hi = 17'($urandom_range(0, 65536));
            if (lo > hi && $urandom_range(4) != 0) begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            write_reg(REG_BAND_A_LOW, lo);
            write_reg(REG_BAND_A_HIGH, hi);
            lo = 17'($urandom_range(0, 65536));
            hi = 17'($urandom_range(0, 65536));
            if (lo > hi && $urandom_range(4) != 0) begin
                tmp = lo;
                lo = hi;
                hi = tmp;
            end
            write_reg(REG_BAND_B_LOW, lo);
            write_reg(REG_BAND_B_HIGH, hi);
            count = $urandom_range(40, 160);
            send_random(count, $urandom_range(0, 100));
            sent += count;
            settle();
        end
    endtask

    // Check each result transfer, pace the receiver and watch for a hang
    always @(posedge clk)
    begin
        res_t exp_res;

        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            if (measurements_due.size() == 0) begin
                $error("result with none expected: tdata %h", m_axis_tdata);
                fault_count++;
            end else begin
                exp_res = measurements_due.pop_front();
                if (m_axis_tdata[1:0] !== exp_res.cls) begin
                    $error("beacon_class: expected %0d, got %0d",
                           exp_res.cls, m_axis_tdata[1:0]);
                    fault_count++;
                end
                if (m_axis_tdata[18:2] !== exp_res.ratio) begin
                    $error("ratio_q16: expected %0d, got %0d",
                           exp_res.ratio, m_axis_tdata[18:2]);
                    fault_count++;
                end
                if (m_axis_tdata[42:19] !== exp_res.low) begin
                    $error("low_total: expected %0d, got %0d",
                           exp_res.low, m_axis_tdata[42:19]);
                    fault_count++;
                end
            end
        end

        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
            stall_cycles = 0;
        else
            stall_cycles++;
        if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end

        if (snk_burst != 0) begin
            snk_burst--;
            m_axis_tready <= 1'b1;
        end else if ($urandom_range(63) == 0) begin
            snk_burst = 24;
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
        end
    end

    initial
    begin
        rst_n <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_WINDOW_SAMPLES;
        cfg_data <= '0;
        src_idle_pct = 0;
        snk_idle_pct = 0;
        src_burst = 0;
        snk_burst = 0;
        fault_count = 0;
        stall_cycles = 0;

        // predictor starts from the reset configuration
        cfg_window = WS_RESET;
        cfg_gap = GS_RESET;
        cfg_windows = WPM_RESET;
        band_a_lo = AL_RESET;
        band_a_hi = AH_RESET;
        band_b_lo = BL_RESET;
        band_b_hi = BH_RESET;
        cnt_low = '0;
        sample_pos = '0;
        win_done = '0;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_band_edges();
        test_inverted_band();
        test_zero_window();
        test_max_windows();
        test_midrun_change();
        test_register_extremes();
        test_random_phase(36, 78);
        test_random_phase(78, 36);
        test_random_phase(0, 0);

        if (fault_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
